[src/dwpid_pkg.sv]
// ----------------------------------------------------------------------------
// dwpid_pkg: shared types and constants for the dual-wheel PID controller
// Widths, register indexes and the control and gain structs.
// ----------------------------------------------------------------------------
package dwpid_pkg;

  // Encoder count width, Q8.8 gain format and integral width.
  localparam int COUNT_WIDTH    = 16;
  localparam int GAIN_WIDTH     = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int SUM_WIDTH      = 32;
  localparam int DRIVE_WIDTH    = 16;

  // Error and delta carry one extra bit so the subtraction is exact.
  localparam int ERR_WIDTH  = COUNT_WIDTH + 1;
  // Raw integral sum before clamping.
  localparam int SUMX_WIDTH = ((SUM_WIDTH > ERR_WIDTH) ? SUM_WIDTH : ERR_WIDTH) + 1;
  // Widest product, and the accumulator of three products.
  localparam int PROD_WIDTH = ((SUM_WIDTH > ERR_WIDTH) ? SUM_WIDTH : ERR_WIDTH) + GAIN_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 2;
  // Integer part of the accumulator.
  localparam int SHIFT_WIDTH = ACC_WIDTH - GAIN_FRAC_BITS;

  // Configuration register indexes.
  localparam int CFG_IDX_WIDTH = 3;
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_LEFT_PROP   = 3'd0,
    CFG_LEFT_INTEG  = 3'd1,
    CFG_LEFT_DERIV  = 3'd2,
    CFG_RIGHT_PROP  = 3'd3,
    CFG_RIGHT_INTEG = 3'd4,
    CFG_RIGHT_DERIV = 3'd5
  } cfg_idx_t;

  // Gains of one wheel.
  typedef struct packed {
    logic signed [GAIN_WIDTH-1:0] kp;
    logic signed [GAIN_WIDTH-1:0] ki;
    logic signed [GAIN_WIDTH-1:0] kd;
  } gains_t;

  // Pipeline control from the sequencer to the datapaths.
  typedef struct packed {
    logic load_s1;  // input word captured into the input register
    logic valid_s1; // input register holds a word
    logic load_s2;  // error, integral and delta stage loads
    logic load_s3;  // product stage loads
    logic load_s4;  // result register loads
  } pipe_ctrl_t;

endpackage

[src/dwpid_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// dwpid_pipe_ctrl: valid and stall sequencing for the four-stage pipeline
// Each stage moves forward when the stage after it is empty or moving.
// ----------------------------------------------------------------------------
module dwpid_pipe_ctrl
  import dwpid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       out_stall,
  output logic       out_valid,
  output pipe_ctrl_t ctrl
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1, ld2, ld3, ld4;

  always_comb begin
    rdy4 = !v4_r || !out_stall;
    ld4  = v3_r && rdy4;
    rdy3 = !v3_r || ld4;
    ld3  = v2_r && rdy3;
    rdy2 = !v2_r || ld3;
    ld2  = v1_r && rdy2;
    rdy1 = !v1_r || ld2;
    ld1  = in_valid && rdy1;

    v1_nxt = ld1 || (v1_r && !ld2);
    v2_nxt = ld2 || (v2_r && !ld3);
    v3_nxt = ld3 || (v3_r && !ld4);
    v4_nxt = ld4 || (v4_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign in_stall      = !rdy1;
  assign out_valid     = v4_r;
  assign ctrl.load_s1  = ld1;
  assign ctrl.valid_s1 = v1_r;
  assign ctrl.load_s2  = ld2;
  assign ctrl.load_s3  = ld3;
  assign ctrl.load_s4  = ld4;

endmodule

[src/dwpid_wheel.sv]
// ----------------------------------------------------------------------------
// dwpid_wheel: PID datapath and loop state for one wheel
// Stage 2 forms error, clamped integral and delta; stage 3 the three
// products; stage 4 the floored, saturated drive and the clip flag.
// ----------------------------------------------------------------------------
module dwpid_wheel
  import dwpid_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  pipe_ctrl_t             ctrl,
  input  gains_t                 gains,
  input  logic [COUNT_WIDTH-1:0] target,
  input  logic [COUNT_WIDTH-1:0] count,
  output logic [DRIVE_WIDTH-1:0] drive,
  output logic                   clipped
);

  // Loop state. total_r also serves as the stage-2 integral operand: it is
  // written exactly when stage 2 loads, so it always matches that word.
  logic [SUM_WIDTH-1:0]   total_r, total_nxt;
  logic [COUNT_WIDTH-1:0] prev_r;

  // Stage 2
  logic [ERR_WIDTH-1:0] err_r, err_nxt;
  logic [ERR_WIDTH-1:0] delta_r, delta_nxt;
  logic                 iclip2_r, iclip2_nxt;
  logic [SUMX_WIDTH-1:0] sum_x;
  logic [SUMX_WIDTH-SUM_WIDTH:0] sum_hi;

  // Stage 3
  logic signed [PROD_WIDTH-1:0] prop_r, prop_nxt;
  logic signed [PROD_WIDTH-1:0] integ_r, integ_nxt;
  logic signed [PROD_WIDTH-1:0] deriv_r, deriv_nxt;
  logic                         iclip3_r;

  // Stage 4
  logic signed [ACC_WIDTH-1:0]   acc;
  logic        [SHIFT_WIDTH-1:0] whole;
  logic [SHIFT_WIDTH-DRIVE_WIDTH:0] whole_hi;
  logic                   dsat;
  logic [DRIVE_WIDTH-1:0] drive_r, drive_nxt;
  logic                   clip_r, clip_nxt;

  always_comb begin
    err_nxt   = {target[COUNT_WIDTH-1], target} - {count[COUNT_WIDTH-1], count};
    delta_nxt = {count[COUNT_WIDTH-1], count} - {prev_r[COUNT_WIDTH-1], prev_r};
    sum_x = {{(SUMX_WIDTH-SUM_WIDTH){total_r[SUM_WIDTH-1]}}, total_r}
          + {{(SUMX_WIDTH-ERR_WIDTH){err_nxt[ERR_WIDTH-1]}}, err_nxt};
    sum_hi = sum_x[SUMX_WIDTH-1:SUM_WIDTH-1];
    iclip2_nxt = !((&sum_hi) || !(|sum_hi));
    if (iclip2_nxt) begin
      total_nxt = sum_x[SUMX_WIDTH-1] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                      : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      total_nxt = sum_x[SUM_WIDTH-1:0];
    end
  end

  always_comb begin
    prop_nxt  = PROD_WIDTH'(gains.kp) * PROD_WIDTH'($signed(err_r));
    integ_nxt = PROD_WIDTH'(gains.ki) * PROD_WIDTH'($signed(total_r));
    deriv_nxt = PROD_WIDTH'(gains.kd) * PROD_WIDTH'($signed(delta_r));
  end

  always_comb begin
    acc = ACC_WIDTH'(prop_r) + ACC_WIDTH'(integ_r) - ACC_WIDTH'(deriv_r);
    // Dropping the fraction bits of a two's complement value is a floor.
    whole    = acc[ACC_WIDTH-1:GAIN_FRAC_BITS];
    whole_hi = whole[SHIFT_WIDTH-1:DRIVE_WIDTH-1];
    dsat     = !((&whole_hi) || !(|whole_hi));
    if (dsat) begin
      drive_nxt = whole[SHIFT_WIDTH-1] ? {1'b1, {(DRIVE_WIDTH-1){1'b0}}}
                                       : {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
    end else begin
      drive_nxt = whole[DRIVE_WIDTH-1:0];
    end
    clip_nxt = iclip3_r || dsat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      prev_r  <= '0;
    end else if (ctrl.load_s2) begin
      total_r <= total_nxt;
      prev_r  <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_s2) begin
      err_r    <= err_nxt;
      delta_r  <= delta_nxt;
      iclip2_r <= iclip2_nxt;
    end
    if (ctrl.load_s3) begin
      prop_r   <= prop_nxt;
      integ_r  <= integ_nxt;
      deriv_r  <= deriv_nxt;
      iclip3_r <= iclip2_r;
    end
    if (ctrl.load_s4) begin
      drive_r <= drive_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign drive   = drive_r;
  assign clipped = clip_r;

endmodule

[src/dual_wheel_pid_controller_unit.sv]
// ----------------------------------------------------------------------------
// dual_wheel_pid_controller_unit: two PID loops, derivative on measurement
// Top level: gain registers, input register, sequencer and two wheels.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Word
//   --------+-----------+----------------------+--------------------------------
//   in_     | input     | in_valid / in_stall   | target, left and right counts
//   out_    | output    | out_valid / out_stall | left/right drive and clip flags
//   cfg_    | input     | cfg_wr_en             | six Q8.8 gains by index
//
// Each word passes through four register stages: the input register, the
// error/integral/delta stage, the product stage and the result register.
// The integral and previous-count update is a single add and clamp per
// cycle, which lets a new word enter on every clock while the output is
// not stalled. Reset (synchronous, rst_n low) empties the pipeline, zeroes
// the gains, both integrals and both previous counts. A stall on the output
// backs up stage by stage, and empty stages still fill, so the input stalls
// only once all four stages hold words.
//
module dual_wheel_pid_controller_unit
  import dwpid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [COUNT_WIDTH-1:0]   in_target_count,
  input  logic [COUNT_WIDTH-1:0]   in_left_count,
  input  logic [COUNT_WIDTH-1:0]   in_right_count,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DRIVE_WIDTH-1:0]   out_left_drive,
  output logic [DRIVE_WIDTH-1:0]   out_right_drive,
  output logic                     out_left_clipped,
  output logic                     out_right_clipped,
  // Configuration port
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [GAIN_WIDTH-1:0]    cfg_data
);

  pipe_ctrl_t ctrl;
  gains_t     left_gains_r, right_gains_r;

  logic [COUNT_WIDTH-1:0] s1_target_r, s1_left_r, s1_right_r;

  // Gain registers. Indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_gains_r  <= '0;
      right_gains_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LEFT_PROP:   left_gains_r.kp  <= cfg_data;
        CFG_LEFT_INTEG:  left_gains_r.ki  <= cfg_data;
        CFG_LEFT_DERIV:  left_gains_r.kd  <= cfg_data;
        CFG_RIGHT_PROP:  right_gains_r.kp <= cfg_data;
        CFG_RIGHT_INTEG: right_gains_r.ki <= cfg_data;
        CFG_RIGHT_DERIV: right_gains_r.kd <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register: holds the accepted word until stage 2 takes it.
  always_ff @(posedge clk) begin
    if (ctrl.load_s1) begin
      s1_target_r <= in_target_count;
      s1_left_r   <= in_left_count;
      s1_right_r  <= in_right_count;
    end
  end

  dwpid_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  dwpid_wheel u_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .gains   (left_gains_r),
    .target  (s1_target_r),
    .count   (s1_left_r),
    .drive   (out_left_drive),
    .clipped (out_left_clipped)
  );

  dwpid_wheel u_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .gains   (right_gains_r),
    .target  (s1_target_r),
    .count   (s1_right_r),
    .drive   (out_right_drive),
    .clipped (out_right_clipped)
  );

`ifndef SYNTH
  // An accepted word is in the input register on the next cycle.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ctrl.valid_s1)
    else $error("accepted word did not reach the input register");

  // Reset leaves no result pending.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A taken result with nothing behind it leaves the output empty.
  a_drain_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !ctrl.load_s4) |=> !out_valid)
    else $error("result repeated after it was taken");

  // A word stalled in the input register stays there until stage 2 takes it.
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.valid_s1 && !ctrl.load_s2 && !ctrl.load_s1) |=> ctrl.valid_s1)
    else $error("stalled word lost from the input register");
`endif

endmodule
